@@ rtl/fcdiv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcdiv_pkg
// Shared constants and types for the fractional clock divider setup block.
// ----------------------------------------------------------------------------
package fcdiv_pkg;

  localparam int FREQ_WIDTH_DEF = 32;   // operand width used by the divider
  localparam int FIELD_W        = 32;   // width of freq_hz, max_freq and each word
  localparam int QUOT_BITS      = 7;    // whole quotient bits, 1 .. 127
  localparam int FRAC_BITS      = 3;    // eighths of the fraction
  localparam int CNT_W          = 2;
  localparam int STAT_W         = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELDS_W = 3 * FIELD_W + CNT_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // register addresses of the divider programming words
  localparam logic [7:0] ADDR_HL = 8'h08;
  localparam logic [7:0] ADDR_FR = 8'h09;
  localparam logic [7:0] ADDR_PM = 8'h07;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_INT  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_FRAC = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_ABOVE = 2'd2,
    ST_RANGE = 2'd3
  } fcdiv_status_t;

  // pack one programming word: address, 16-bit register, count byte
  function automatic logic [FIELD_W-1:0] make_word(input logic [7:0] addr,
                                                   input logic [15:0] regv,
                                                   input logic [CNT_W-1:0] cnt);
    make_word = {addr, regv, 6'd0, cnt};
  endfunction

endpackage

@@ rtl/fractional_clock_divider_setup_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_clock_divider_setup_top
// Divides the reference frequency by a requested frequency and builds the
// divider programming words for registers 08h, 09h and 07h, a word count and a status.
// ----------------------------------------------------------------------------
// One request is taken per clock while the pipeline is not stalled. Each
// word runs through an input register, ten compare-and-subtract stages of a
// restoring long division (seven whole quotient bits, then three eighths
// bits) and an output register on its way to m_tvalid. The stages hold
// their words on a stall and empty stages fill while the output waits.
// max_freq is written through cfg_wr_en / cfg_wr_data and resets to 1; the
// user must write it only while idle, the block itself does not enforce it.
module fractional_clock_divider_setup_top #(
  parameter int FREQ_WIDTH = fcdiv_pkg::FREQ_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [fcdiv_pkg::FIELD_W-1:0]       cfg_wr_data,  // max_freq
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [fcdiv_pkg::IN_TDATA_W-1:0]    s_tdata,      // [31:0] freq_hz
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] word_08, [63:32] word_09, [95:64] word_07, [97:96] word_count,
  // [99:98] status, [103:100] zero
  output logic [fcdiv_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import fcdiv_pkg::*;

  localparam int W      = (FREQ_WIDTH < FIELD_W) ? FREQ_WIDTH : FIELD_W;
  localparam int QB     = QUOT_BITS;
  localparam int QF_W   = QUOT_BITS + FRAC_BITS;
  localparam int STEPS  = QF_W;

  logic [FIELD_W-1:0] max_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_freq <= FIELD_W'(1);
    end else if (cfg_wr_en) begin
      max_freq <= cfg_wr_data;
    end
  end

  // stage 0 is the input register, stages 1 .. STEPS are division steps
  logic            v    [STEPS+1];
  logic            ld   [STEPS+1];
  logic [W-1:0]    f_s  [STEPS+1];
  logic [W-1:0]    r_s  [STEPS+1];
  logic [QF_W-1:0] qf_s [STEPS+1];
  logic            nz_s [STEPS+1];
  fcdiv_status_t   st_s [STEPS+1];

  logic                   ov;
  logic [OUT_TDATA_W-1:0] o_data;
  logic [OUT_TDATA_W-1:0] o_data_next;
  logic                   ld_out;

  assign ld_out = !ov || m_tready;

  genvar j;
  generate
    for (j = 0; j <= STEPS; j++) begin : g_ld
      if (j == STEPS) begin : g_last
        assign ld[j] = !v[j] || ld_out;
      end else begin : g_mid
        assign ld[j] = !v[j] || ld[j+1];
      end
    end
  endgenerate

  assign s_tready = ld[0];

  // input stage: take operands, classify the request
  logic [W-1:0]  f_in;
  logic [W-1:0]  m_in;
  fcdiv_status_t st_in;

  assign f_in = s_tdata[W-1:0];
  assign m_in = max_freq[W-1:0];

  always_comb begin
    if (f_in == '0) begin
      st_in = ST_ZERO;
    end else if (f_in > m_in) begin
      st_in = ST_ABOVE;
    end else if ((m_in >> QB) >= f_in) begin
      st_in = ST_RANGE;   // quotient above 127
    end else begin
      st_in = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ld[0]) begin
      v[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      f_s[0]  <= f_in;
      r_s[0]  <= m_in;
      qf_s[0] <= '0;
      nz_s[0] <= 1'b0;
      st_s[0] <= st_in;
    end
  end

  // division steps: whole quotient bits first, then eighths
  generate
    for (j = 1; j <= STEPS; j++) begin : g_step
      logic         ge;
      logic [W-1:0] r_new;
      logic         nz_new;

      if (j <= QB) begin : g_int
        localparam int K = QB - j;
        logic [W+QB-1:0] sh;
        logic [W+QB-1:0] rw;
        logic [W+QB-1:0] diff;
        assign sh    = (W+QB)'(f_s[j-1]) << K;
        assign rw    = (W+QB)'(r_s[j-1]);
        assign ge    = rw >= sh;
        assign diff  = rw - sh;
        assign r_new = ge ? diff[W-1:0] : r_s[j-1];
      end else begin : g_frac
        logic [W:0] r2;
        logic [W:0] diff;
        assign r2    = {r_s[j-1], 1'b0};
        assign ge    = r2 >= {1'b0, f_s[j-1]};
        assign diff  = r2 - {1'b0, f_s[j-1]};
        assign r_new = ge ? diff[W-1:0] : r2[W-1:0];
      end

      if (j == QB) begin : g_nz
        assign nz_new = r_new != '0;   // remainder of the whole divide
      end else begin : g_nzp
        assign nz_new = nz_s[j-1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[j] <= 1'b0;
        end else if (ld[j]) begin
          v[j] <= v[j-1];
        end
      end

      always_ff @(posedge clk) begin
        if (ld[j]) begin
          f_s[j]  <= f_s[j-1];
          r_s[j]  <= r_new;
          qf_s[j] <= {qf_s[j-1][QF_W-2:0], ge};
          nz_s[j] <= nz_new;
          st_s[j] <= st_s[j-1];
        end
      end
    end
  endgenerate

  // word assembly
  always_comb begin
    logic [QB-1:0]        q;
    logic [FRAC_BITS-1:0] frac;
    logic                 edge_b;
    logic [5:0]           hi;
    logic [5:0]           lo;
    logic [3:0]           ef;
    logic                 wfall;
    logic                 wrise;
    logic [2:0]           pmfall;
    logic                 rz;
    logic [15:0]          r08;
    logic [15:0]          r09;
    logic [15:0]          r07;
    logic [CNT_W-1:0]     cnt;
    fcdiv_status_t        st;

    q      = qf_s[STEPS][QF_W-1:FRAC_BITS];
    frac   = qf_s[STEPS][FRAC_BITS-1:0];
    rz     = r_s[STEPS] == '0;
    edge_b = q[0];
    ef     = {edge_b, frac};
    pmfall = {edge_b, frac[2:1]};
    hi     = q[QB-1:1];
    lo     = q[QB-1:1];
    wfall  = 1'b0;
    wrise  = 1'b0;
    r08    = '0;
    r09    = '0;
    r07    = '0;
    cnt    = CNT_NONE;
    st     = st_s[STEPS];

    if (st == ST_OK && nz_s[STEPS] && q < QB'(2)) begin
      st = ST_RANGE;   // fractional divide below two
    end

    if (st == ST_OK) begin
      if (!nz_s[STEPS]) begin
        // low count of 64 wraps to 0 in its field
        lo  = 6'(7'(q[QB-1:1]) + 7'(edge_b));
        r08 = {4'b0001, hi, lo};
        r09 = {8'd0, edge_b, 7'd0};
        r07 = '0;
        cnt = CNT_INT;
      end else begin
        if (ef <= 4'd8) begin
          hi = hi - 6'd1;
          lo = lo - 6'd1;
        end else if (ef == 4'd9) begin
          lo = lo - 6'd1;
        end
        wfall = (ef >= 4'd2 && ef <= 4'd9) ||
                (q == QB'(2) && frac == 3'd1 && rz);
        wrise = ef >= 4'd1 && ef <= 4'd8;
        r08 = {4'b0001, hi, lo};
        r09 = {1'b0, frac, 1'b1, wrise, 10'd0};
        r07 = {2'b00, pmfall, wfall, 10'd0};
        cnt = CNT_FRAC;
      end
    end

    o_data_next = '0;
    if (st == ST_OK) begin
      o_data_next[FIELD_W-1:0]           = make_word(ADDR_HL, r08, cnt);
      o_data_next[2*FIELD_W-1:FIELD_W]   = make_word(ADDR_FR, r09, cnt);
      o_data_next[3*FIELD_W-1:2*FIELD_W] = make_word(ADDR_PM, r07, cnt);
    end
    o_data_next[3*FIELD_W +: CNT_W]          = cnt;
    o_data_next[3*FIELD_W + CNT_W +: STAT_W] = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ld_out) begin
      ov <= v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      o_data <= o_data_next;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = o_data;

  // an error result carries no words
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3*FIELD_W + CNT_W +: STAT_W] != ST_OK |->
      m_tdata[3*FIELD_W + CNT_W - 1:0] == '0)
    else $error("error result with nonzero words");

  // a good result is an integer or a fractional divide
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3*FIELD_W + CNT_W +: STAT_W] == ST_OK |->
      (m_tdata[3*FIELD_W +: CNT_W] == CNT_INT ||
       m_tdata[3*FIELD_W +: CNT_W] == CNT_FRAC))
    else $error("good result with bad word count");

  // input is held back only when the first stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v[0])
    else $error("input stalled with empty first stage");

  // the pipeline comes out of reset empty
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
